FILE: rtl/itf_pkg.sv
// Package: transfer types, constants and character helpers of the integer formatter.
package itf_pkg;

    localparam int NUM_CELLS = 64;
    localparam int DIG_W     = 6;
    localparam int NDIG_W    = 7;
    localparam int LEN_W     = 8;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam int FLAG_ZERO   = 0;
    localparam int FLAG_SIGNED = 1;
    localparam int FLAG_PLUS   = 2;
    localparam int FLAG_SPACE  = 3;
    localparam int FLAG_LEFT   = 4;
    localparam int FLAG_PREFIX = 5;
    localparam int FLAG_UPPER  = 6;

    localparam logic [7:0] RADIX_MIN = 8'd2;
    localparam logic [7:0] RADIX_MAX = 8'd36;
    localparam logic [7:0] RADIX_BIN = 8'd2;
    localparam logic [7:0] RADIX_OCT = 8'd8;
    localparam logic [7:0] RADIX_HEX = 8'd16;

    localparam logic [DIG_W-1:0] DIG_B = 6'd11;
    localparam logic [DIG_W-1:0] DIG_X = 6'd33;

    typedef struct packed {
        logic signed [63:0] value;
        logic [7:0]         radix;
        logic [6:0]         field_width;
        logic [6:0]         min_digits;
        logic [6:0]         format_flags;
    } t_fmt_in;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_char;
        logic       truncated;
        logic       bad_radix;
    } t_fmt_out;

    // Map a digit value 0..35 to its character: a decimal digit, or a letter from a upward.
    function automatic logic [7:0] digit_char(input logic [DIG_W-1:0] d, input logic upper);
        logic [7:0] base;
        begin
            base = upper ? CH_UP_A : CH_LO_A;
            if (d < 6'd10) begin
                digit_char = CH_ZERO + {2'b00, d};
            end else begin
                digit_char = base + {2'b00, d} - 8'd10;
            end
        end
    endfunction

endpackage

FILE: rtl/integer_to_text_formatter_unit.sv
// Top level: printf-style integer to text formatter with a digit-cell converter.
// An item is taken when start is high and busy is low. A radix outside 2..36 gives its single
// error result in the next cycle and the block stays free. Otherwise busy holds while the item
// is converted and sent, at most MAX_OUTPUT characters: the magnitude is fed one bit a cycle, most
// significant first, through the array of 64 base-radix digit cells (double and carry in one
// step), the states ST_SIZE and ST_PLAN plan the field layout, and then one character leaves per
// cycle while no digit waits for the leading one. Before the first digit the cell array shifts
// up until the leading digit reaches the top cell; these shifts run alongside the leading
// spaces, sign, prefix and zeros, and digits wait for them only when those are shorter. Each
// result is on o_result for one cycle under o_strobe, and the receiver cannot stall the block.
module integer_to_text_formatter_unit #(
    parameter int MAX_OUTPUT = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  itf_pkg::t_fmt_in  i_item,
    output logic            o_strobe,
    output itf_pkg::t_fmt_out o_result
);
    import itf_pkg::*;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_OUTPUT);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_CONV = 5'b00010,
        ST_SIZE = 5'b00100,
        ST_PLAN = 5'b01000,
        ST_EMIT = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic [5:0]        r_cnt, n_cnt;
    logic [63:0]       r_mag, n_mag;
    logic [DIG_W-1:0]  r_cell [NUM_CELLS];
    logic [DIG_W-1:0]  n_cell [NUM_CELLS];
    logic [NDIG_W-1:0] r_ndig, n_ndig;
    logic [DIG_W-1:0]  r_radix, n_radix;
    logic [DIG_W-1:0]  r_half_up, n_half_up;
    logic [DIG_W-1:0]  r_half_dn, n_half_dn;
    logic              r_odd, n_odd;
    logic              r_upper, n_upper;
    logic              r_zero, n_zero;
    logic              r_left, n_left;
    logic              r_sign_len, n_sign_len;
    logic [7:0]        r_sign_char, n_sign_char;
    logic [1:0]        r_pre_len, n_pre_len;
    logic [7:0]        r_pre_char, n_pre_char;
    logic [6:0]        r_min_dig, n_min_dig;
    logic [6:0]        r_width, n_width;
    logic [6:0]        r_prec, n_prec;
    logic [LEN_W-1:0]  r_content, n_content;
    logic [5:0]        r_norm, n_norm;
    logic [LEN_W-1:0]  r_b1, n_b1;
    logic [LEN_W-1:0]  r_b2, n_b2;
    logic [LEN_W-1:0]  r_b3, n_b3;
    logic [LEN_W-1:0]  r_b5, n_b5;
    logic [LEN_W-1:0]  r_b6, n_b6;
    logic [LEN_W-1:0]  r_total, n_total;
    logic [LEN_W-1:0]  r_pos, n_pos;
    logic              r_out_vld, n_out_vld;
    t_fmt_out          r_out, n_out;

    logic [NUM_CELLS-1:0] gen_v;
    logic [NUM_CELLS-1:0] prp_v;
    logic [NUM_CELLS:0]   csum;
    logic [NUM_CELLS:0]   carry;
    logic [DIG_W-1:0]     cell_conv [NUM_CELLS];
    logic [DIG_W-1:0]     cell_shift [NUM_CELLS];
    logic [DIG_W:0]       dbl [NUM_CELLS];

    logic              bad;
    logic              neg;
    logic [6:0]        flags;
    logic [6:0]        prec_max;
    logic [8:0]        diff;
    logic [LEN_W-1:0]  pad;
    logic [LEN_W-1:0]  lpad;
    logic [LEN_W-1:0]  zpad;
    logic [LEN_W-1:0]  zeros;
    logic [LEN_W-1:0]  pos_inc;
    logic              in_dig;
    logic              emit_ok;
    logic              last;
    logic [7:0]        ch;
    logic [6:0]        half_sum;

    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = r_out_vld;
    assign o_result = r_out;

    // Digit-cell array: double every cell and add the incoming bit with one carry chain.
    always_comb begin
        for (int i = 0; i < NUM_CELLS; i++) begin
            gen_v[i] = (r_cell[i] >= r_half_up);
            prp_v[i] = r_odd && (r_cell[i] == r_half_dn);
        end
        csum = {1'b0, gen_v | prp_v} + {1'b0, gen_v} + {{NUM_CELLS{1'b0}}, r_mag[63]};
        carry[NUM_CELLS-1:0] = csum[NUM_CELLS-1:0] ^ (gen_v | prp_v) ^ gen_v;
        carry[NUM_CELLS]     = csum[NUM_CELLS];
        for (int i = 0; i < NUM_CELLS; i++) begin
            dbl[i] = {r_cell[i], 1'b0} + {{DIG_W{1'b0}}, carry[i]};
            if (carry[i+1]) begin
                cell_conv[i] = DIG_W'(dbl[i] - {1'b0, r_radix});
            end else begin
                cell_conv[i] = dbl[i][DIG_W-1:0];
            end
            if (i == 0) begin
                cell_shift[i] = '0;
            end else begin
                cell_shift[i] = r_cell[i-1];
            end
        end
    end

    always_comb begin
        flags    = i_item.format_flags;
        bad      = (i_item.radix < RADIX_MIN) || (i_item.radix > RADIX_MAX);
        neg      = flags[FLAG_SIGNED] && i_item.value[63];
        half_sum = {1'b0, i_item.radix[5:0]} + 7'd1;

        prec_max = (7'(r_ndig) > r_min_dig) ? 7'(r_ndig) : r_min_dig;

        diff  = {2'b00, r_width} - {1'b0, r_content};
        pad   = diff[8] ? '0 : diff[LEN_W-1:0];
        lpad  = (!r_zero && !r_left) ? pad : '0;
        zpad  = r_zero ? pad : '0;
        zeros = LEN_W'(r_prec - 7'(r_ndig));

        pos_inc = r_pos + 8'd1;
        in_dig  = (r_pos >= r_b5) && (r_pos < r_b6);
        emit_ok = !in_dig || (r_norm == '0);
        last    = (pos_inc == r_total) || (pos_inc == MAX_LEN);

        priority if (r_pos < r_b1) begin
            ch = CH_SPACE;
        end else if (r_pos < r_b2) begin
            ch = r_sign_char;
        end else if (r_pos < r_b3) begin
            ch = (r_pos == r_b2) ? CH_ZERO : r_pre_char;
        end else if (r_pos < r_b5) begin
            ch = CH_ZERO;
        end else if (r_pos < r_b6) begin
            ch = digit_char(r_cell[NUM_CELLS-1], r_upper);
        end else begin
            ch = CH_SPACE;
        end

        n_state     = r_state;
        n_cnt       = r_cnt;
        n_mag       = r_mag;
        n_cell      = r_cell;
        n_ndig      = r_ndig;
        n_radix     = r_radix;
        n_half_up   = r_half_up;
        n_half_dn   = r_half_dn;
        n_odd       = r_odd;
        n_upper     = r_upper;
        n_zero      = r_zero;
        n_left      = r_left;
        n_sign_len  = r_sign_len;
        n_sign_char = r_sign_char;
        n_pre_len   = r_pre_len;
        n_pre_char  = r_pre_char;
        n_min_dig   = r_min_dig;
        n_width     = r_width;
        n_prec      = r_prec;
        n_content   = r_content;
        n_norm      = r_norm;
        n_b1        = r_b1;
        n_b2        = r_b2;
        n_b3        = r_b3;
        n_b5        = r_b5;
        n_b6        = r_b6;
        n_total     = r_total;
        n_pos       = r_pos;
        n_out_vld   = 1'b0;
        n_out       = r_out;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    if (bad) begin
                        n_out_vld       = 1'b1;
                        n_out.out_char  = CH_NUL;
                        n_out.last_char = 1'b1;
                        n_out.truncated = 1'b0;
                        n_out.bad_radix = 1'b1;
                    end else begin
                        n_state   = ST_CONV;
                        n_cnt     = '0;
                        n_mag     = neg ? (64'd0 - i_item.value) : i_item.value;
                        for (int i = 0; i < NUM_CELLS; i++) begin
                            n_cell[i] = '0;
                        end
                        n_ndig    = NDIG_W'(1);
                        n_radix   = i_item.radix[5:0];
                        n_half_up = half_sum[6:1];
                        n_half_dn = DIG_W'((i_item.radix[5:0] - 6'd1) >> 1);
                        n_odd     = i_item.radix[0];
                        n_upper   = flags[FLAG_UPPER];
                        n_left    = flags[FLAG_LEFT];
                        n_zero    = flags[FLAG_ZERO] && !flags[FLAG_LEFT];
                        n_min_dig = i_item.min_digits;
                        n_width   = i_item.field_width;
                        n_pos     = '0;
                        if (neg) begin
                            n_sign_len  = 1'b1;
                            n_sign_char = CH_MINUS;
                        end else if (flags[FLAG_SIGNED] && flags[FLAG_PLUS]) begin
                            n_sign_len  = 1'b1;
                            n_sign_char = CH_PLUS;
                        end else if (flags[FLAG_SIGNED] && flags[FLAG_SPACE]) begin
                            n_sign_len  = 1'b1;
                            n_sign_char = CH_SPACE;
                        end else begin
                            n_sign_len  = 1'b0;
                            n_sign_char = CH_SPACE;
                        end
                        n_pre_len  = 2'd0;
                        n_pre_char = CH_ZERO;
                        if (flags[FLAG_PREFIX]) begin
                            if (i_item.radix == RADIX_OCT) begin
                                n_pre_len = 2'd1;
                            end else if (i_item.radix == RADIX_BIN) begin
                                n_pre_len  = 2'd2;
                                n_pre_char = digit_char(DIG_B, flags[FLAG_UPPER]);
                            end else if (i_item.radix == RADIX_HEX) begin
                                n_pre_len  = 2'd2;
                                n_pre_char = digit_char(DIG_X, flags[FLAG_UPPER]);
                            end
                        end
                    end
                end
            end
            ST_CONV: begin
                n_cell = cell_conv;
                n_mag  = {r_mag[62:0], 1'b0};
                n_cnt  = r_cnt + 6'd1;
                if (carry[r_ndig]) begin
                    n_ndig = r_ndig + NDIG_W'(1);
                end
                if (&r_cnt) begin
                    n_state = ST_SIZE;
                end
            end
            ST_SIZE: begin
                n_prec    = prec_max;
                n_content = LEN_W'(prec_max) + LEN_W'(r_pre_len) + LEN_W'(r_sign_len);
                n_norm    = 6'(NDIG_W'(NUM_CELLS) - r_ndig);
                n_state   = ST_PLAN;
            end
            ST_PLAN: begin
                n_b1    = lpad;
                n_b2    = lpad + LEN_W'(r_sign_len);
                n_b3    = lpad + LEN_W'(r_sign_len) + LEN_W'(r_pre_len);
                n_b5    = lpad + zpad + LEN_W'(r_sign_len) + LEN_W'(r_pre_len) + zeros;
                n_b6    = lpad + zpad + r_content;
                n_total = pad + r_content;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if ((r_norm != '0) || (emit_ok && in_dig)) begin
                    n_cell = cell_shift;
                end
                if (r_norm != '0) begin
                    n_norm = r_norm - 6'd1;
                end
                if (emit_ok) begin
                    n_out_vld       = 1'b1;
                    n_out.out_char  = ch;
                    n_out.last_char = last;
                    n_out.truncated = last && (r_total > MAX_LEN);
                    n_out.bad_radix = 1'b0;
                    n_pos           = pos_inc;
                    if (last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt       <= n_cnt;
        r_mag       <= n_mag;
        r_cell      <= n_cell;
        r_ndig      <= n_ndig;
        r_radix     <= n_radix;
        r_half_up   <= n_half_up;
        r_half_dn   <= n_half_dn;
        r_odd       <= n_odd;
        r_upper     <= n_upper;
        r_zero      <= n_zero;
        r_left      <= n_left;
        r_sign_len  <= n_sign_len;
        r_sign_char <= n_sign_char;
        r_pre_len   <= n_pre_len;
        r_pre_char  <= n_pre_char;
        r_min_dig   <= n_min_dig;
        r_width     <= n_width;
        r_prec      <= n_prec;
        r_content   <= n_content;
        r_norm      <= n_norm;
        r_b1        <= n_b1;
        r_b2        <= n_b2;
        r_b3        <= n_b3;
        r_b5        <= n_b5;
        r_b6        <= n_b6;
        r_total     <= n_total;
        r_pos       <= n_pos;
        r_out       <= n_out;
    end

endmodule
